// ===== rtl/ikp_pkg.sv =====
// Shared types, constants and helper functions for the leg inverse kinematics unit.
package ikp_pkg;

  localparam int XW           = 18;
  localparam int SQ_W         = 62;
  localparam int RT_W         = 31;
  localparam int SQ_STAGES    = 31;
  localparam int CW           = 44;
  localparam int AW           = 21;
  localparam int CORDIC_STEPS = 16;
  localparam int CO_LAT       = 20;
  localparam int NORM_BIT     = 40;
  localparam int PI_Q16       = 205887;
  localparam int LAT_FLOOR    = 268;
  localparam int REACH_MARGIN = 2;

  localparam logic [2:0] CFG_HIP_X     = 3'd0;
  localparam logic [2:0] CFG_HIP_Y     = 3'd1;
  localparam logic [2:0] CFG_ABD_LEN   = 3'd2;
  localparam logic [2:0] CFG_UPPER_LEN = 3'd3;
  localparam logic [2:0] CFG_LOWER_LEN = 3'd4;
  localparam logic [2:0] CFG_MIN_REACH = 3'd5;

  localparam logic [13:0] RST_HIP_X     = 14'd3169;
  localparam logic [13:0] RST_HIP_Y     = 14'd762;
  localparam logic [13:0] RST_ABD_LEN   = 14'd1565;
  localparam logic [13:0] RST_UPPER_LEN = 14'd3490;
  localparam logic [13:0] RST_LOWER_LEN = 14'd3490;
  localparam logic [13:0] RST_MIN_REACH = 14'd1802;

  typedef struct packed {
    logic [1:0]         leg_index;
    logic signed [15:0] foot_x;
    logic signed [15:0] foot_y;
    logic signed [15:0] foot_z;
  } ikp_in_t;

  typedef struct packed {
    logic signed [15:0] hip_angle;
    logic signed [15:0] thigh_angle;
    logic signed [15:0] knee_angle;
    logic               reach_clamped;
  } ikp_out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
    logic signed [XW-1:0] loff;
    logic [16:0]          r;
    logic                 clamped;
    logic signed [31:0]   nk;
    logic signed [31:0]   np;
  } ikp_side_t;

  function automatic logic signed [AW-1:0] atan_val(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0:       v = AW'(51472);
      1:       v = AW'(30386);
      2:       v = AW'(16055);
      3:       v = AW'(8150);
      4:       v = AW'(4091);
      5:       v = AW'(2047);
      6:       v = AW'(1024);
      7:       v = AW'(512);
      8:       v = AW'(256);
      9:       v = AW'(128);
      10:      v = AW'(64);
      11:      v = AW'(32);
      12:      v = AW'(16);
      13:      v = AW'(8);
      14:      v = AW'(4);
      15:      v = AW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] to_q12(input logic signed [AW+1:0] v);
    logic signed [AW+1:0] t;
    t = (v + (AW+2)'(8)) >>> 4;
    if (t > $signed((AW+2)'(32767))) begin
      return 16'sh7fff;
    end else if (t < -$signed((AW+2)'(32768))) begin
      return 16'sh8000;
    end
    return t[15:0];
  endfunction

endpackage

// ===== rtl/ikp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a carried side beat.
module ikp_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_i,
  input  logic [ikp_pkg::SQ_W-1:0]  rad_i,
  input  ikp_pkg::ikp_side_t        side_i,
  output logic                      vld_o,
  output logic [ikp_pkg::RT_W-1:0]  root_o,
  output ikp_pkg::ikp_side_t        side_o
);
  import ikp_pkg::*;

  logic [SQ_W-1:0] v_r   [SQ_STAGES];
  logic [SQ_W:0]   res_r [SQ_STAGES];
  logic            vld_r [SQ_STAGES];
  ikp_side_t       side_r[SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
    localparam logic [SQ_W:0] BIT = {{SQ_W{1'b0}}, 1'b1} << (2 * (SQ_STAGES - 1 - k));
    logic [SQ_W-1:0] v_in, v_out;
    logic [SQ_W:0]   res_in, res_out, trial;
    logic            vld_in;
    ikp_side_t       side_in;

    if (k == 0) begin : g_first
      assign v_in    = rad_i;
      assign res_in  = '0;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign res_in  = res_r[k-1];
      assign vld_in  = vld_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if ({1'b0, v_in} >= trial) begin
        v_out   = v_in - trial[SQ_W-1:0];
        res_out = (res_in >> 1) + BIT;
      end else begin
        v_out   = v_in;
        res_out = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]    <= v_out;
        res_r[k]  <= res_out;
        side_r[k] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end
  end

  assign vld_o  = vld_r[SQ_STAGES-1];
  assign root_o = res_r[SQ_STAGES-1][RT_W-1:0];
  assign side_o = side_r[SQ_STAGES-1];

endmodule

// ===== rtl/ikp_cordic.sv =====
// Pipelined sixteen-step vectoring CORDIC giving atan2 in Q16 radians.
module ikp_cordic (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [31:0]              y_i,
  input  logic signed [31:0]              x_i,
  output logic signed [ikp_pkg::AW-1:0]   ang_o
);
  import ikp_pkg::*;

  logic signed [32:0]   px, py;
  logic [32:0]          ax, ay;
  logic signed [AW-1:0] pbase;
  logic                 pzero;

  logic signed [CW-1:0] p_x_r, p_y_r;
  logic [CW-1:0]        p_mm_r;
  logic signed [AW-1:0] p_base_r;
  logic                 p_zero_r;

  logic signed [CW-1:0] n1x, n1y;
  logic [CW-1:0]        n1m;
  logic signed [CW-1:0] n1_x_r, n1_y_r;
  logic [CW-1:0]        n1_mm_r;
  logic signed [AW-1:0] n1_base_r;
  logic                 n1_zero_r;

  logic signed [CW-1:0] n2x, n2y;
  logic [CW-1:0]        n2m;
  logic signed [CW-1:0] n2_x_r, n2_y_r;
  logic signed [AW-1:0] n2_base_r;
  logic                 n2_zero_r;

  logic signed [CW-1:0] it_x_r   [CORDIC_STEPS];
  logic signed [CW-1:0] it_y_r   [CORDIC_STEPS];
  logic signed [AW-1:0] it_a_r   [CORDIC_STEPS];
  logic signed [AW-1:0] it_base_r[CORDIC_STEPS];
  logic                 it_zero_r[CORDIC_STEPS];

  always_comb begin
    pzero = (x_i == '0) && (y_i == '0);
    pbase = '0;
    px    = 33'(x_i);
    py    = 33'(y_i);
    if (x_i < 0) begin
      px    = -33'(x_i);
      py    = -33'(y_i);
      pbase = (y_i >= 0) ? AW'(PI_Q16) : -AW'(PI_Q16);
    end
    ax = (px < 0) ? 33'(-px) : 33'(px);
    ay = (py < 0) ? 33'(-py) : 33'(py);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x_r    <= CW'(px);
      p_y_r    <= CW'(py);
      p_mm_r   <= CW'(ax | ay);
      p_base_r <= pbase;
      p_zero_r <= pzero;
    end
  end

  always_comb begin
    n1x = p_x_r;
    n1y = p_y_r;
    n1m = p_mm_r;
    if ((n1m >> (NORM_BIT - 32)) == '0) begin
      n1x = n1x <<< 32;
      n1y = n1y <<< 32;
      n1m = n1m << 32;
    end
    if ((n1m >> (NORM_BIT - 16)) == '0) begin
      n1x = n1x <<< 16;
      n1y = n1y <<< 16;
      n1m = n1m << 16;
    end
    if ((n1m >> (NORM_BIT - 8)) == '0) begin
      n1x = n1x <<< 8;
      n1y = n1y <<< 8;
      n1m = n1m << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_x_r    <= n1x;
      n1_y_r    <= n1y;
      n1_mm_r   <= n1m;
      n1_base_r <= p_base_r;
      n1_zero_r <= p_zero_r;
    end
  end

  always_comb begin
    n2x = n1_x_r;
    n2y = n1_y_r;
    n2m = n1_mm_r;
    if ((n2m >> (NORM_BIT - 4)) == '0) begin
      n2x = n2x <<< 4;
      n2y = n2y <<< 4;
      n2m = n2m << 4;
    end
    if ((n2m >> (NORM_BIT - 2)) == '0) begin
      n2x = n2x <<< 2;
      n2y = n2y <<< 2;
      n2m = n2m << 2;
    end
    if ((n2m >> (NORM_BIT - 1)) == '0) begin
      n2x = n2x <<< 1;
      n2y = n2y <<< 1;
    end
    n2x = n2x <<< 1;
    n2y = n2y <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_x_r    <= n2x;
      n2_y_r    <= n2y;
      n2_base_r <= n1_base_r;
      n2_zero_r <= n1_zero_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    logic signed [CW-1:0] cx, cy, nx, ny;
    logic signed [AW-1:0] ca, na, cb;
    logic                 cz;

    if (i == 0) begin : g_first
      assign cx = n2_x_r;
      assign cy = n2_y_r;
      assign ca = '0;
      assign cb = n2_base_r;
      assign cz = n2_zero_r;
    end else begin : g_next
      assign cx = it_x_r[i-1];
      assign cy = it_y_r[i-1];
      assign ca = it_a_r[i-1];
      assign cb = it_base_r[i-1];
      assign cz = it_zero_r[i-1];
    end

    always_comb begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        na = ca + atan_val(i);
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        na = ca - atan_val(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_x_r[i]    <= nx;
        it_y_r[i]    <= ny;
        it_a_r[i]    <= na;
        it_base_r[i] <= cb;
        it_zero_r[i] <= cz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_o <= it_zero_r[CORDIC_STEPS-1] ? '0 :
               it_base_r[CORDIC_STEPS-1] + it_a_r[CORDIC_STEPS-1];
    end
  end

endmodule

// ===== rtl/leg_inverse_kinematics_unit.sv =====
// Top level of the three-joint leg inverse kinematics pipeline.
//
//   channel | direction | ports                          | beat
//   in      | input     | in_valid, in_stall, in_data    | leg index and foot target
//   out     | output    | out_valid, out_stall, out_data | three joint angles and clamp flag
//   cfg     | input     | cfg_we, cfg_index, cfg_wdata   | one geometry register
//
// One beat is accepted per cycle while in_stall is low; in_stall is high while the skid register is full.
// A beat runs through three 31-stage square root pipelines in series and the 20-stage CORDIC units.
// Reset is synchronous and clears the valid bits and loads the default geometry.
// An output stall holds the whole pipeline only once the skid register is also full.
module leg_inverse_kinematics_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ikp_pkg::ikp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ikp_pkg::ikp_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [13:0]       cfg_wdata
);
  import ikp_pkg::*;

  logic [13:0] hip_x_r, hip_y_r, abd_r, l1_r, l2_r, minr_r;
  logic        pipe_en;

  logic                 a_vld_r;
  ikp_side_t            a_side_r, a_side_nxt;

  logic                 b_vld_r;
  ikp_side_t            b_side_r;
  logic signed [2*XW-1:0] b_yy_r, b_zz_r, b_ll_r;

  logic                 c_vld_r;
  ikp_side_t            c_side_r;
  logic [2*XW-1:0]      c_s_r;
  logic signed [2*XW:0] s_full;

  logic                 sq1_vld;
  logic [RT_W-1:0]      sq1_root;
  ikp_side_t            sq1_side;

  logic                 d_vld_r;
  ikp_side_t            d_side_r, d_side_nxt;
  logic [33:0]          d_rr_r;
  logic signed [2*XW-1:0] d_xx_r;

  logic                 e_vld_r;
  ikp_side_t            e_side_r;
  logic [2*XW-1:0]      e_q_r;

  logic                 sq2_vld;
  logic [RT_W-1:0]      sq2_root;
  ikp_side_t            sq2_side;

  logic [16:0]          draw;
  logic [14:0]          hi_sum, hi;
  logic [16:0]          d_lo, d_cap;
  logic                 f_vld_r;
  ikp_side_t            f_side_r, f_side_nxt;
  logic [14:0]          f_d_r;

  logic                 g_vld_r;
  ikp_side_t            g_side_r;
  logic [27:0]          g_l1l1_r, g_l2l2_r, g_l1l2_r;
  logic [29:0]          g_dd_r;
  logic [28:0]          g_l1d_r;

  logic                 h_vld_r;
  ikp_side_t            h_side_r;
  logic signed [31:0]   h_nk_r, h_mk_r, h_np_r, h_mp_r;

  logic signed [31:0]   nkc, npc;
  logic                 i_vld_r;
  ikp_side_t            i_side_r, i_side_nxt;
  logic [RT_W-1:0]      i_ak_r, i_bk_r, i_ap_r, i_bp_r;

  logic                 j_vld_r;
  ikp_side_t            j_side_r;
  logic [SQ_W-1:0]      pk_full, pp_full, j_pk_r, j_pp_r;

  logic                 sq3_vld;
  logic [RT_W-1:0]      sq3_root_k, sq3_root_p;
  ikp_side_t            sq3_side;
  logic                 psi_vld;
  ikp_side_t            psi_side;

  logic signed [AW-1:0] ang0, ang1, ang2, ang3, ang4;
  logic                 co_vld_r [CO_LAT];
  logic                 co_flag_r[CO_LAT];

  logic                 tail_vld;
  ikp_out_t             tail_res;
  logic signed [AW+1:0] q1, q2, q3;

  logic                 out_valid_r, skid_valid_r, take;
  ikp_out_t             out_data_r, skid_data_r;

  assign pipe_en  = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hip_x_r <= RST_HIP_X;
      hip_y_r <= RST_HIP_Y;
      abd_r   <= RST_ABD_LEN;
      l1_r    <= RST_UPPER_LEN;
      l2_r    <= RST_LOWER_LEN;
      minr_r  <= RST_MIN_REACH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIP_X:     hip_x_r <= cfg_wdata;
        CFG_HIP_Y:     hip_y_r <= cfg_wdata;
        CFG_ABD_LEN:   abd_r   <= cfg_wdata;
        CFG_UPPER_LEN: l1_r    <= cfg_wdata;
        CFG_LOWER_LEN: l2_r    <= cfg_wdata;
        CFG_MIN_REACH: minr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hip offsets are removed according to the leg's front/rear and left/right signs.
  always_comb begin
    logic signed [XW-1:0] fx, fy, hx, hy, ab;
    fx = XW'(in_data.foot_x);
    fy = XW'(in_data.foot_y);
    hx = $signed({{(XW-14){1'b0}}, hip_x_r});
    hy = $signed({{(XW-14){1'b0}}, hip_y_r});
    ab = $signed({{(XW-14){1'b0}}, abd_r});
    a_side_nxt      = '0;
    a_side_nxt.x    = in_data.leg_index[1] ? fx + hx : fx - hx;
    a_side_nxt.y    = in_data.leg_index[0] ? fy + hy : fy - hy;
    a_side_nxt.z    = XW'(in_data.foot_z);
    a_side_nxt.loff = in_data.leg_index[0] ? -ab : ab;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
      j_vld_r <= 1'b0;
    end else if (pipe_en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= sq1_vld;
      e_vld_r <= d_vld_r;
      f_vld_r <= sq2_vld;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
      j_vld_r <= i_vld_r;
    end
  end

  always_comb begin
    s_full = (2*XW+1)'(b_yy_r) + (2*XW+1)'(b_zz_r) - (2*XW+1)'(b_ll_r);
  end

  always_comb begin
    d_side_nxt   = sq1_side;
    d_side_nxt.r = sq1_root[16:0];
  end

  always_comb begin
    draw   = sq2_root[16:0];
    hi_sum = {1'b0, l1_r} + {1'b0, l2_r};
    hi     = (hi_sum < 15'(REACH_MARGIN)) ? '0 : hi_sum - 15'(REACH_MARGIN);
    d_lo   = (draw < {3'b0, minr_r}) ? {3'b0, minr_r} : draw;
    d_cap  = (d_lo > {2'b0, hi}) ? {2'b0, hi} : d_lo;
    f_side_nxt         = sq2_side;
    f_side_nxt.clamped = (d_cap != draw);
  end

  always_comb begin
    nkc = h_nk_r;
    if (h_nk_r > h_mk_r) begin
      nkc = h_mk_r;
    end else if (h_nk_r < -h_mk_r) begin
      nkc = -h_mk_r;
    end
    npc = h_np_r;
    if (h_np_r > h_mp_r) begin
      npc = h_mp_r;
    end else if (h_np_r < -h_mp_r) begin
      npc = -h_mp_r;
    end
    i_side_nxt    = h_side_r;
    i_side_nxt.nk = nkc;
    i_side_nxt.np = npc;
  end

  assign pk_full = i_ak_r * i_bk_r;
  assign pp_full = i_ap_r * i_bp_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_side_r <= a_side_nxt;
      b_side_r <= a_side_r;
      b_yy_r   <= a_side_r.y * a_side_r.y;
      b_zz_r   <= a_side_r.z * a_side_r.z;
      b_ll_r   <= a_side_r.loff * a_side_r.loff;
      c_side_r <= b_side_r;
      c_s_r    <= (s_full < $signed((2*XW+1)'(LAT_FLOOR))) ? (2*XW)'(LAT_FLOOR)
                                                            : s_full[2*XW-1:0];
      d_side_r <= d_side_nxt;
      d_rr_r   <= d_side_nxt.r * d_side_nxt.r;
      d_xx_r   <= sq1_side.x * sq1_side.x;
      e_side_r <= d_side_r;
      e_q_r    <= d_xx_r[2*XW-1:0] + (2*XW)'(d_rr_r);
      f_side_r <= f_side_nxt;
      f_d_r    <= d_cap[14:0];
      g_side_r <= f_side_r;
      g_l1l1_r <= l1_r * l1_r;
      g_l2l2_r <= l2_r * l2_r;
      g_l1l2_r <= l1_r * l2_r;
      g_dd_r   <= f_d_r * f_d_r;
      g_l1d_r  <= l1_r * f_d_r;
      h_side_r <= g_side_r;
      h_nk_r   <= $signed(32'(g_l1l1_r) + 32'(g_l2l2_r) - 32'(g_dd_r));
      h_mk_r   <= $signed(32'({g_l1l2_r, 1'b0}));
      h_np_r   <= $signed(32'(g_l1l1_r) + 32'(g_dd_r) - 32'(g_l2l2_r));
      h_mp_r   <= $signed(32'({g_l1d_r, 1'b0}));
      i_side_r <= i_side_nxt;
      i_ak_r   <= RT_W'(h_mk_r - nkc);
      i_bk_r   <= RT_W'(h_mk_r + nkc);
      i_ap_r   <= RT_W'(h_mp_r - npc);
      i_bp_r   <= RT_W'(h_mp_r + npc);
      j_side_r <= i_side_r;
      j_pk_r   <= pk_full;
      j_pp_r   <= pp_full;
    end
  end

  ikp_isqrt u_sqrt_lat (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .vld_i  (c_vld_r),
    .rad_i  ({{(SQ_W-2*XW){1'b0}}, c_s_r}),
    .side_i (c_side_r),
    .vld_o  (sq1_vld),
    .root_o (sq1_root),
    .side_o (sq1_side)
  );

  ikp_isqrt u_sqrt_reach (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .vld_i  (e_vld_r),
    .rad_i  ({{(SQ_W-2*XW){1'b0}}, e_q_r}),
    .side_i (e_side_r),
    .vld_o  (sq2_vld),
    .root_o (sq2_root),
    .side_o (sq2_side)
  );

  ikp_isqrt u_sqrt_knee (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .vld_i  (j_vld_r),
    .rad_i  (j_pk_r),
    .side_i (j_side_r),
    .vld_o  (sq3_vld),
    .root_o (sq3_root_k),
    .side_o (sq3_side)
  );

  ikp_isqrt u_sqrt_psi (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .vld_i  (j_vld_r),
    .rad_i  (j_pp_r),
    .side_i (j_side_r),
    .vld_o  (psi_vld),
    .root_o (sq3_root_p),
    .side_o (psi_side)
  );

  ikp_cordic u_atan_lat (
    .clk   (clk),
    .en    (pipe_en),
    .y_i   (32'(sq3_side.z)),
    .x_i   (32'(sq3_side.y)),
    .ang_o (ang0)
  );

  ikp_cordic u_atan_abd (
    .clk   (clk),
    .en    (pipe_en),
    .y_i   ($signed(32'(sq3_side.r))),
    .x_i   (32'(sq3_side.loff)),
    .ang_o (ang1)
  );

  ikp_cordic u_atan_fwd (
    .clk   (clk),
    .en    (pipe_en),
    .y_i   (-32'(sq3_side.x)),
    .x_i   ($signed(32'(sq3_side.r))),
    .ang_o (ang2)
  );

  ikp_cordic u_atan_knee (
    .clk   (clk),
    .en    (pipe_en),
    .y_i   ($signed({1'b0, sq3_root_k})),
    .x_i   (sq3_side.nk),
    .ang_o (ang3)
  );

  ikp_cordic u_atan_psi (
    .clk   (clk),
    .en    (pipe_en),
    .y_i   ($signed({1'b0, sq3_root_p})),
    .x_i   (sq3_side.np),
    .ang_o (ang4)
  );

  for (genvar k = 0; k < CO_LAT; k++) begin : g_co
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        co_vld_r[k] <= 1'b0;
      end else if (pipe_en) begin
        co_vld_r[k] <= (k == 0) ? sq3_vld : co_vld_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        co_flag_r[k] <= (k == 0) ? sq3_side.clamped : co_flag_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_comb begin
    q1 = (AW+2)'(ang0) + (AW+2)'(ang1);
    q2 = (AW+2)'(ang2) + (AW+2)'(ang4);
    q3 = (AW+2)'(ang3) - (AW+2)'(PI_Q16);
    tail_vld               = co_vld_r[CO_LAT-1];
    tail_res.hip_angle     = to_q12(q1);
    tail_res.thigh_angle   = to_q12(q2);
    tail_res.knee_angle    = to_q12(q3);
    tail_res.reach_clamped = co_flag_r[CO_LAT-1];
  end

  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (tail_vld) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (tail_vld) begin
      if (!out_valid_r || take) begin
        out_data_r <= tail_res;
      end else begin
        skid_data_r <= tail_res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid register is full while the output register is empty.");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall && tail_vld))
    else $error("Skid register filled without a stalled result and a new one.");

  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_en && tail_vld) |=> tail_vld)
    else $error("A result left the pipeline tail while it was held.");

  a_skid_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !take) |=> $stable(skid_data_r))
    else $error("Skid data changed while waiting.");

  a_root_align: assert property (@(posedge clk) disable iff (!rst_n)
    (sq3_vld || psi_vld) |-> (sq3_vld && psi_vld && psi_side == sq3_side))
    else $error("The two angle square roots lost step with each other.");
`endif

endmodule

// ===== bench/ik_angle_checker.sv =====
`timescale 1ns / 1ps
// Watches the leg inverse kinematics channels, predicts the joint angles and compares them.
module ik_angle_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  ikp_pkg::ikp_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  ikp_pkg::ikp_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [13:0]       cfg_wdata,
  output int                fails,
  output int                pending,
  output int                results,
  output int                clamped_seen
);
  import ikp_pkg::*;

  localparam int ATAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint PI_Q = 205887;

  logic [13:0] hip_x, hip_y, abd_len, upper_len, lower_len, min_reach;
  ikp_out_t    angle_queue [$];

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint abs_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint base, ang, nx, ny;
    base = 0;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? PI_Q : -PI_Q;
      x = -x;
      y = -y;
    end
    while (abs_of(x) < (64'sd1 <<< 40) && abs_of(y) < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        ang = ang + ATAN_Q16[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        ang = ang - ATAN_Q16[i];
      end
      x = nx;
      y = ny;
    end
    return base + ang;
  endfunction

  function automatic longint cosine_angle(longint n, longint m);
    if (n > m) n = m;
    if (n < -m) n = -m;
    return vector_angle(root_floor(longint'(m * m - n * n)), n);
  endfunction

  function automatic logic signed [15:0] round_q12(longint v);
    longint t;
    t = (v + 8) >>> 4;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  function automatic ikp_out_t predict_joints(ikp_in_t item);
    longint side, fwd, l1, l2, loff, x, y, z, s, r, draw, d, hi, q1, q2, q3;
    ikp_out_t res;
    side = item.leg_index[0] ? -1 : 1;
    fwd = item.leg_index[1] ? -1 : 1;
    l1 = upper_len;
    l2 = lower_len;
    loff = side * longint'(abd_len);
    x = longint'(item.foot_x) - fwd * longint'(hip_x);
    y = longint'(item.foot_y) - side * longint'(hip_y);
    z = longint'(item.foot_z);
    s = y * y + z * z - loff * loff;
    if (s < 268) s = 268;
    r = root_floor(s);
    draw = root_floor(x * x + r * r);
    hi = l1 + l2 - 2;
    if (hi < 0) hi = 0;
    d = draw;
    if (d < longint'(min_reach)) d = min_reach;
    if (d > hi) d = hi;
    q1 = vector_angle(z, y) + vector_angle(r, loff);
    q3 = cosine_angle(l1 * l1 + l2 * l2 - d * d, 2 * l1 * l2) - PI_Q;
    q2 = vector_angle(-x, r) + cosine_angle(l1 * l1 + d * d - l2 * l2, 2 * l1 * d);
    res.hip_angle = round_q12(q1);
    res.thigh_angle = round_q12(q2);
    res.knee_angle = round_q12(q3);
    res.reach_clamped = (d != draw);
    return res;
  endfunction

  always @(posedge clk) begin
    ikp_out_t want;
    if (!rst_n) begin
      hip_x <= RST_HIP_X;
      hip_y <= RST_HIP_Y;
      abd_len <= RST_ABD_LEN;
      upper_len <= RST_UPPER_LEN;
      lower_len <= RST_LOWER_LEN;
      min_reach <= RST_MIN_REACH;
      angle_queue.delete();
      fails <= 0;
      pending <= 0;
      results <= 0;
      clamped_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HIP_X:     hip_x <= cfg_wdata;
          CFG_HIP_Y:     hip_y <= cfg_wdata;
          CFG_ABD_LEN:   abd_len <= cfg_wdata;
          CFG_UPPER_LEN: upper_len <= cfg_wdata;
          CFG_LOWER_LEN: lower_len <= cfg_wdata;
          CFG_MIN_REACH: min_reach <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        angle_queue.insert(angle_queue.size(), predict_joints(in_data));
      end
      if (out_valid && !out_stall) begin
        results <= results + 1;
        if (out_data.reach_clamped) clamped_seen <= clamped_seen + 1;
        if (angle_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fails <= fails + 1;
        end else begin
          want = angle_queue.pop_front();
          if (want.hip_angle !== out_data.hip_angle ||
              want.thigh_angle !== out_data.thigh_angle ||
              want.knee_angle !== out_data.knee_angle ||
              want.reach_clamped !== out_data.reach_clamped) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            fails <= fails + 1;
          end
        end
      end
      pending <= angle_queue.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Stimulus, clocking and verdict for the leg inverse kinematics unit.
module tb;
  import ikp_pkg::*;

  localparam int WATCH_LIMIT = 4000;
  localparam logic [1:0] FRONT_LEFT = 2'd0, FRONT_RIGHT = 2'd1;
  localparam logic [1:0] REAR_LEFT = 2'd2, REAR_RIGHT = 2'd3;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  ikp_in_t     in_data;
  ikp_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [13:0] cfg_wdata;
  logic        in_taken, out_taken, idling;
  int          fails, pending, results, clamped_seen, quiet, sent;

  leg_inverse_kinematics_unit dut (.*);

  ik_angle_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
  end

  always @(negedge clk) out_stall <= idling && ($urandom_range(99) < 19);

  always @(negedge clk) begin
    if (!rst_n || in_taken || out_taken) begin
      quiet <= 0;
    end else if (quiet >= WATCH_LIMIT) begin
      $display("[leg_inverse_kinematics_unit] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_target(logic [1:0] leg, logic [15:0] fx, logic [15:0] fy,
                             logic [15:0] fz);
    while (idling && $urandom_range(99) < 19) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{leg, fx, fy, fz};
    do @(negedge clk); while (!in_taken);
    in_valid = 1'b0;
    sent++;
  endtask

  task automatic drain_results();
    while (pending != 0 || in_taken) @(negedge clk);
  endtask

  task automatic write_geometry(logic [13:0] hx, logic [13:0] hy, logic [13:0] abd,
                                logic [13:0] up, logic [13:0] lo, logic [13:0] mr);
    logic [13:0] vals [6];
    vals = '{hx, hy, abd, up, lo, mr};
    drain_results();
    repeat (140) @(negedge clk);
    drain_results();
    for (int i = 0; i < 6; i++) begin
      cfg_we = 1'b1;
      cfg_index = 3'(i);
      cfg_wdata = vals[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic random_targets(int count);
    int c;
    logic [1:0] leg;
    for (int k = 0; k < count; k++) begin
      leg = 2'($urandom_range(3));
      c = $urandom_range(99);
      if (k == count / 2) drain_results();
      if (c < 65) begin
        send_target(leg, 16'($signed($urandom_range(12000)) - 6000),
                    16'($signed($urandom_range(8000)) - 4000),
                    16'(-$signed($urandom_range(8000))));
      end else begin
        send_target(leg, 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_HIP_X;
    cfg_wdata = '0;
    idling = 1'b1;
    out_stall = 1'b0;
    sent = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send_target(FRONT_LEFT, 16'sd3169, 16'sd762, 16'sd0);
    send_target(FRONT_RIGHT, 16'sd3169, -16'sd2327, 16'sd0);
    send_target(REAR_LEFT, -16'sd3169, 16'sd2327, -16'sd4500);
    send_target(REAR_RIGHT, -16'sd3169, -16'sd2327, -16'sd4500);
    send_target(FRONT_LEFT, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_target(FRONT_RIGHT, 16'sh8000, 16'sh8000, 16'sh8000);
    send_target(REAR_LEFT, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_target(REAR_RIGHT, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_target(FRONT_LEFT, 16'sd0, 16'sd0, 16'sd0);
    send_target(FRONT_LEFT, 16'sd3169, 16'sd762, -16'sd1000);
    send_target(REAR_RIGHT, -16'sd1000, -16'sd2000, -16'sd5000);
    send_target(FRONT_RIGHT, 16'sd5000, 16'sd1000, -16'sd6900);
    send_target(REAR_LEFT, -16'sd3169, 16'sd2327, -16'sd1);
    send_target(FRONT_LEFT, 16'sd3169, 16'sd2327, 16'sd20000);

    random_targets(200);
    idling = 1'b0;
    random_targets(150);
    idling = 1'b1;
    write_geometry(14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff);
    random_targets(200);
    write_geometry(14'd0, 14'd0, 14'd0, 14'd1, 14'd1, 14'd1);
    random_targets(170);
    write_geometry(14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
    random_targets(100);
    write_geometry(14'd2000, 14'd500, 14'd1000, 14'd1500, 14'd1200, 14'h3fff);
    random_targets(170);
    write_geometry(14'd3169, 14'd762, 14'd0, 14'd3490, 14'd3490, 14'd1802);
    random_targets(100);
    for (int p = 0; p < 3; p++) begin
      write_geometry(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom),
                     14'($urandom), 14'($urandom));
      random_targets(110);
    end

    drain_results();
    repeat (200) @(negedge clk);
    $display("Sent %0d foot targets over nine geometry settings, %0d results checked.",
             sent, results);
    $display("%0d results had the reach clamped.", clamped_seen);
    if (fails == 0 && pending == 0) begin
      $display("[leg_inverse_kinematics_unit] OK");
    end else begin
      $display("[leg_inverse_kinematics_unit] ERROR");
    end
    $finish;
  end

endmodule
